/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/tdp_pkg.sv */
package tdp_pkg;

	// field widths
	localparam int VAL_W  = 16;
	localparam int PROD_W = 2 * VAL_W;

	// default table depth for the top level
	localparam int TABLE_DEPTH_DEF = 64;

	// bound after reset
	localparam logic [VAL_W-1:0] BOUND_RESET = VAL_W'(100);

	// smallest number that can be prime
	localparam logic [VAL_W-1:0] MIN_PRIME = VAL_W'(2);

	typedef struct packed {
		logic [VAL_W-1:0] candidate;
		logic             restart;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             is_prime;
		logic             out_of_range;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_FETCH,
		ST_CHECK,
		ST_DIV,
		ST_SQUARE,
		ST_APPEND,
		ST_FINISH
	} state_t;

endpackage

/* hdl/tdp_table.sv */
module tdp_table #(
	parameter int DEPTH = tdp_pkg::TABLE_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [AW-1:0]           wr_addr,
	input  logic [tdp_pkg::VAL_W-1:0] wr_data,
	input  logic                    rd_en,
	input  logic [AW-1:0]           rd_addr,
	output logic [tdp_pkg::VAL_W-1:0] rd_data
);

	logic [tdp_pkg::VAL_W-1:0] mem [DEPTH];
	logic [tdp_pkg::VAL_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/tdp_divider.sv */
module tdp_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tdp_pkg::VAL_W-1:0] dividend,
	input  logic [tdp_pkg::VAL_W-1:0] divisor,
	output logic                      done,
	output logic [tdp_pkg::VAL_W-1:0] remainder
);

	localparam int W  = tdp_pkg::VAL_W;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dvs_q;
	logic [W-1:0]  rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0] trial;
	logic [W:0] diff;

	// one restoring step per cycle, dividend bits enter msb first
	assign trial = {rem_q, dvd_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// done pulses once after the last step
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[W-1:0];
			end else begin
				rem_q <= trial[W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

/* hdl/trial_division_prime_tester_top.sv */
// channel  | direction | handshake          | payload
// in       | to block  | in_valid/in_stall  | in_data (candidate, restart)
// out      | from block| out_valid/out_stall| out_data (value, is_prime, out_of_range)
// cfg      | to block  | cfg_wr_en          | cfg_wr_data (upper_bound)
//
// one candidate at a time; each stored prime is tried by the bit-serial remainder unit
// in read, fetch, check, div; table end or a prime whose square reaches the bound goes
// via square and append to finish; a divisor, out of range or below two go to finish.
// arst_n clears the prime count, the state and the output valid; table contents
// are not cleared, entries beyond the count are never read.
// a new candidate can transfer while the previous result waits under out_stall.
module trial_division_prime_tester_top #(
	parameter int TABLE_DEPTH = tdp_pkg::TABLE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  tdp_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output tdp_pkg::out_item_t        out_data,
	input  logic                      cfg_wr_en,
	input  logic [tdp_pkg::VAL_W-1:0] cfg_wr_data
);

	localparam int W  = tdp_pkg::VAL_W;
	localparam int PW = tdp_pkg::PROD_W;
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	tdp_pkg::state_t state_q, state_d;

	logic [W-1:0]  bound_q;
	logic [W-1:0]  cand_q;
	logic          prime_q;
	logic          oor_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] count_q;
	logic [W-1:0]  p_q;
	logic [PW-1:0] sq_q;
	logic          out_valid_q;
	tdp_pkg::out_item_t out_q;

	logic          in_xfer;
	logic          out_free;
	logic          in_oor;
	logic          sq_below;
	logic          rd_en;
	logic          wr_en;
	logic          div_start;
	logic          div_done;
	logic [W-1:0]  div_rem;
	logic [W-1:0]  rd_data;
	logic [W-1:0]  mul_a;

	assign in_stall = (state_q != tdp_pkg::ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_oor   = (in_data.candidate >= bound_q);
	assign sq_below = (sq_q < PW'(bound_q));

	// squaring multiplier, stored prime while walking, candidate before append
	assign mul_a = (state_q == tdp_pkg::ST_FETCH) ? rd_data : cand_q;

	// prime table memory
	tdp_table #(
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (cand_q),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// remainder unit
	tdp_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (cand_q),
		.divisor   (p_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			tdp_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (in_oor || in_data.candidate < tdp_pkg::MIN_PRIME) begin
						state_d = tdp_pkg::ST_FINISH;
					end else begin
						state_d = tdp_pkg::ST_READ;
					end
				end
			end
			tdp_pkg::ST_READ: begin
				if (idx_q >= count_q) begin
					state_d = tdp_pkg::ST_SQUARE;
				end else begin
					rd_en   = 1'b1;
					state_d = tdp_pkg::ST_FETCH;
				end
			end
			tdp_pkg::ST_FETCH: begin
				state_d = tdp_pkg::ST_CHECK;
			end
			tdp_pkg::ST_CHECK: begin
				if (!sq_below) begin
					state_d = tdp_pkg::ST_SQUARE;
				end else if (p_q == '0) begin
					state_d = tdp_pkg::ST_READ;
				end else begin
					div_start = 1'b1;
					state_d   = tdp_pkg::ST_DIV;
				end
			end
			tdp_pkg::ST_DIV: begin
				if (div_done) begin
					if (div_rem == '0) begin
						state_d = tdp_pkg::ST_FINISH;
					end else begin
						state_d = tdp_pkg::ST_READ;
					end
				end
			end
			tdp_pkg::ST_SQUARE: begin
				state_d = tdp_pkg::ST_APPEND;
			end
			tdp_pkg::ST_APPEND: begin
				wr_en   = prime_q && (count_q < CW'(TABLE_DEPTH)) && sq_below;
				state_d = tdp_pkg::ST_FINISH;
			end
			tdp_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = tdp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tdp_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers: bound, count, walk index, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q     <= tdp_pkg::BOUND_RESET;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				bound_q <= cfg_wr_data;
			end
			if (in_xfer) begin
				idx_q <= '0;
				if (in_data.restart) begin
					count_q <= '0;
				end
			end
			if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			// next prime after a skipped zero entry or a nonzero remainder
			if ((state_q == tdp_pkg::ST_CHECK && sq_below && p_q == '0) ||
				(state_q == tdp_pkg::ST_DIV && div_done && div_rem != '0)) begin
				idx_q <= idx_q + CW'(1);
			end
			// result valid: set on finish, cleared once taken
			if (state_q == tdp_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cand_q  <= in_data.candidate;
			oor_q   <= in_oor;
			prime_q <= !in_oor && (in_data.candidate >= tdp_pkg::MIN_PRIME);
		end
		if (state_q == tdp_pkg::ST_DIV && div_done && div_rem == '0) begin
			prime_q <= 1'b0;
		end
		if (state_q == tdp_pkg::ST_FETCH) begin
			p_q <= rd_data;
		end
		if (state_q == tdp_pkg::ST_FETCH || state_q == tdp_pkg::ST_SQUARE) begin
			sq_q <= PW'(mul_a) * PW'(mul_a);
		end
		if (state_q == tdp_pkg::ST_FINISH && out_free) begin
			out_q.value        <= cand_q;
			out_q.is_prime     <= prime_q;
			out_q.out_of_range <= oor_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* hdl/tdp_checker.sv */
`include "assert_macros.svh"

module tdp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input tdp_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input tdp_pkg::out_item_t out_data
);

	// a result out of range never claims to be prime
	`ASSERT_SAME(a_oor_not_prime, out_valid && out_data.out_of_range, !out_data.is_prime, "out of range result marked prime")

	// a prime result is at least two
	`ASSERT_SAME(a_prime_min, out_valid && out_data.is_prime, out_data.value >= tdp_pkg::MIN_PRIME, "prime result below two")

	// one candidate at a time: the block is busy right after an input transfer
	`ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input taken twice in a row")

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind trial_division_prime_tester_top tdp_checker u_tdp_checker (.*);
